### hw/rtl/dmsh_pkg.sv
// ----------------------------------------------------------------------------
// dmsh_pkg
// shared types and constants for the double-modulus substring hash block
// ----------------------------------------------------------------------------
package dmsh_pkg;

    localparam int MAX_LEN   = 4096;
    localparam int ADDR_W    = $clog2(MAX_LEN);
    localparam int LEN_W     = $clog2(MAX_LEN + 1);
    localparam int WORD_W    = 30;
    localparam int ENTRY_W   = 2 * WORD_W;
    localparam int HASH_W    = 60;
    localparam int KIND_W    = 2;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_APPEND = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_MOD_ONE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MOD_TWO  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_ONE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_TWO = 2'd3;

    localparam logic [WORD_W-1:0] MOD_RESET    = 30'd998244353;
    localparam logic [WORD_W-1:0] BASE1_RESET  = 30'd9001;
    localparam logic [WORD_W-1:0] BASE2_RESET  = 30'd9007;

    // width of a reduction operand: 60-bit product plus addend
    localparam int RED_W = 61;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [7:0]         char_byte;
        logic [12:0]        range_start;
        logic [12:0]        range_end;
    } in_item_t;

    typedef struct packed {
        logic [HASH_W-1:0]   hash_value;
        logic [STATUS_W-1:0] status;
    } out_item_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [WORD_W-1:0]    data;
    } cfg_item_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RD_A,
        S_WAIT_A,
        S_LOAD_A,
        S_APP_P1,
        S_APP_H1,
        S_APP_P2,
        S_APP_H2,
        S_APP_WR,
        S_RD_B,
        S_WAIT_B,
        S_Q_RED_HR1,
        S_Q_RED_HR2,
        S_Q_RED_HL1,
        S_Q_RED_HL2,
        S_Q_RED_PW1,
        S_Q_RED_PW2,
        S_Q_MUL1,
        S_Q_MUL2,
        S_Q_NUM1,
        S_Q_NUM2,
        S_Q_COMB,
        S_OUT
    } state_t;

    typedef struct packed {
        logic                start;
        logic [RED_W-1:0]    operand;
        logic [WORD_W-1:0]   modulus;
    } red_req_t;

    typedef struct packed {
        logic                done;
        logic [WORD_W-1:0]   remainder;
    } red_rsp_t;

endpackage

### hw/rtl/dmsh_if.sv
// ----------------------------------------------------------------------------
// dmsh_if
// valid/ready channel carrying one item of a given payload type
// ----------------------------------------------------------------------------
interface dmsh_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### hw/rtl/dmsh_ram.sv
// ----------------------------------------------------------------------------
// dmsh_ram
// generic single-port synchronous ram with registered read
// ----------------------------------------------------------------------------
module dmsh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

### hw/rtl/dmsh_reducer.sv
// ----------------------------------------------------------------------------
// dmsh_reducer
// bit-serial restoring reduction of a 61-bit operand by a runtime modulus
// ----------------------------------------------------------------------------
module dmsh_reducer (
    input  logic              clk,
    input  logic              rst_n,
    input  dmsh_pkg::red_req_t req,
    output dmsh_pkg::red_rsp_t rsp
);
    import dmsh_pkg::*;

    localparam int CNT_W = $clog2(RED_W + 1);

    logic [RED_W-1:0]  op_reg, op_next;
    logic [WORD_W:0]   rem_reg, rem_next;
    logic [WORD_W-1:0] mod_reg, mod_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [WORD_W+1:0] shifted;
    logic [WORD_W+1:0] diff;

    always_comb
    begin
        shifted   = {rem_reg, op_reg[RED_W-1]};
        diff      = shifted - {2'b00, mod_reg};
        op_next   = op_reg;
        rem_next  = rem_reg;
        mod_next  = mod_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            op_next   = req.operand;
            rem_next  = '0;
            mod_next  = (req.modulus == '0) ? WORD_W'(1) : req.modulus;
            cnt_next  = CNT_W'(RED_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            op_next  = {op_reg[RED_W-2:0], 1'b0};
            rem_next = diff[WORD_W+1] ? shifted[WORD_W:0] : diff[WORD_W:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        rem_reg <= rem_next;
        mod_reg <= mod_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg[WORD_W-1:0];
endmodule

### hw/rtl/double_modular_substring_hash.sv
// ----------------------------------------------------------------------------
// double_modular_substring_hash
// prefix rolling hashes under two moduli kept in ram, with substring queries
// ----------------------------------------------------------------------------
// usage:
//   in_ch carries items (kind, char_byte, range_start, range_end); out_ch
//   returns one item (hash_value, status) per input item, in order.
//   cfg_ch writes modulus_one, modulus_two, base_one, base_two by index;
//   the user must write them only while the block is idle, which the
//   block itself does not enforce. one item is worked at a time. all
//   modular reductions go through one shared bit-serial reducer: an
//   append takes eight reductions, a valid nonempty query eight
//   reductions plus ram reads; clear, kind 3, empty range and flagged
//   items need no reduction. the next item is taken in the cycle its
//   predecessor's result appears.
//   the hash and power rams are read-modify-written; no two accesses of
//   one item overlap, so no forwarding is needed.
//   reset empties the string and loads register defaults; ram contents
//   stay undefined and need no clearing pass.
//   while out_ch is stalled the result holds in the output register; the
//   next item is still worked, then waits until the output register frees.
// ----------------------------------------------------------------------------
module double_modular_substring_hash (
    input  logic clk,
    input  logic rst_n,
    dmsh_if.sink   in_ch,
    dmsh_if.source out_ch,
    dmsh_if.sink   cfg_ch
);
    import dmsh_pkg::*;

    state_t state_reg, state_next;

    logic [WORD_W-1:0] mod1_reg, mod2_reg, base1_reg, base2_reg;
    logic [LEN_W-1:0]  len_reg, len_next;
    in_item_t          item_reg, item_next;
    out_item_t         res_reg, res_next;
    out_item_t         out_data_reg, out_data_next;
    logic              out_valid_reg, out_valid_next;

    // working registers
    logic [WORD_W-1:0] h1_reg, h1_next, h2_reg, h2_next;
    logic [WORD_W-1:0] p1_reg, p1_next, p2_reg, p2_next;
    logic [WORD_W-1:0] a1_reg, a1_next, a2_reg, a2_next;
    logic [ENTRY_W-1:0] prod_reg, prod_next;

    // rams: hash pair and power pair
    logic               h_we, p_we;
    logic [ADDR_W-1:0]  ram_addr;
    logic [ENTRY_W-1:0] h_wdata, p_wdata, h_rdata, p_rdata;

    dmsh_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_LEN)) u_hash_ram (
        .clk(clk), .we(h_we), .addr(ram_addr), .wdata(h_wdata), .rdata(h_rdata)
    );
    dmsh_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_LEN)) u_pow_ram (
        .clk(clk), .we(p_we), .addr(ram_addr), .wdata(p_wdata), .rdata(p_rdata)
    );

    red_req_t red_req;
    red_rsp_t red_rsp;
    dmsh_reducer u_reducer (.clk(clk), .rst_n(rst_n), .req(red_req), .rsp(red_rsp));

    logic              in_acc;
    logic [LEN_W-1:0]  l_ext, r_ext, diff_len;
    logic              q_bad;
    logic [WORD_W-1:0] m1_eff;

    assign in_acc   = in_ch.valid && in_ch.ready;
    assign in_ch.ready  = (state_reg == S_IDLE);
    assign cfg_ch.ready = 1'b1;
    assign out_ch.valid   = out_valid_reg;
    assign out_ch.payload = out_data_reg;

    assign l_ext    = LEN_W'(item_reg.range_start);
    assign r_ext    = LEN_W'(item_reg.range_end);
    assign diff_len = r_ext - l_ext;
    assign q_bad    = (l_ext > r_ext) || (r_ext > len_reg);
    assign m1_eff   = (mod1_reg == '0) ? WORD_W'(1) : mod1_reg;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod1_reg  <= MOD_RESET;
            mod2_reg  <= MOD_RESET;
            base1_reg <= BASE1_RESET;
            base2_reg <= BASE2_RESET;
        end
        else if (cfg_ch.valid)
        begin
            case (cfg_ch.payload.index)
                REG_MOD_ONE:  mod1_reg  <= cfg_ch.payload.data;
                REG_MOD_TWO:  mod2_reg  <= cfg_ch.payload.data;
                REG_BASE_ONE: base1_reg <= cfg_ch.payload.data;
                REG_BASE_TWO: base2_reg <= cfg_ch.payload.data;
                default:      mod1_reg  <= mod1_reg;
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        item_next      = item_reg;
        res_next       = res_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;
        h1_next = h1_reg; h2_next = h2_reg;
        p1_next = p1_reg; p2_next = p2_reg;
        a1_next = a1_reg; a2_next = a2_reg;
        prod_next = prod_reg;
        h_we = 1'b0;
        p_we = 1'b0;
        ram_addr = '0;
        h_wdata  = {h2_reg, h1_reg};
        p_wdata  = {p2_reg, p1_reg};
        red_req  = '0;

        if (out_ch.valid && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    item_next = in_ch.payload;
                    state_next = S_RD_A;
                end
            end
            S_RD_A:
            begin
                res_next = '{hash_value: '0, status: ST_OK};
                case (item_reg.kind)
                    KIND_CLEAR:
                    begin
                        len_next = '0;
                        state_next = S_OUT;
                    end
                    KIND_APPEND:
                    begin
                        if (len_reg == LEN_W'(MAX_LEN))
                        begin
                            res_next.status = ST_FULL;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            ram_addr = ADDR_W'(len_reg - LEN_W'(1));
                            state_next = S_WAIT_A;
                        end
                    end
                    KIND_QUERY:
                    begin
                        if (q_bad)
                        begin
                            res_next.status = ST_BAD_RANGE;
                            state_next = S_OUT;
                        end
                        else if (l_ext == r_ext)
                        begin
                            state_next = S_OUT;
                        end
                        else
                        begin
                            // read h[r] and p[r-l]
                            ram_addr = ADDR_W'(r_ext - LEN_W'(1));
                            state_next = S_WAIT_A;
                        end
                    end
                    default: state_next = S_OUT;
                endcase
            end
            S_WAIT_A:
            begin
                // hash ram holds h[r] or h[n]; power ram read needs own address
                if (item_reg.kind == KIND_APPEND)
                begin
                    ram_addr = ADDR_W'(len_reg - LEN_W'(1));
                end
                else
                begin
                    ram_addr = ADDR_W'(diff_len - LEN_W'(1));
                end
                if (item_reg.kind == KIND_APPEND && len_reg == '0)
                begin
                    h1_next = '0; h2_next = '0;
                end
                else
                begin
                    h1_next = h_rdata[WORD_W-1:0];
                    h2_next = h_rdata[ENTRY_W-1:WORD_W];
                end
                state_next = S_LOAD_A;
            end
            S_LOAD_A:
            begin
                if (item_reg.kind == KIND_APPEND)
                begin
                    if (len_reg == '0)
                    begin
                        p1_next = WORD_W'(1); p2_next = WORD_W'(1);
                    end
                    else
                    begin
                        p1_next = p_rdata[WORD_W-1:0];
                        p2_next = p_rdata[ENTRY_W-1:WORD_W];
                    end
                    prod_next = ENTRY_W'(0);
                    state_next = S_APP_P1;
                    red_req.start = 1'b0;
                end
                else
                begin
                    p1_next = p_rdata[WORD_W-1:0];
                    p2_next = p_rdata[ENTRY_W-1:WORD_W];
                    state_next = S_RD_B;
                end
            end
            // append: each step multiplies then reduces; power and hash
            // values are reduced first since stored values may exceed m
            S_APP_P1:
            begin
                if (red_rsp.done || prod_reg == '0)
                begin
                    if (prod_reg != '0) a1_next = red_rsp.remainder;
                end
                if (prod_reg == '0)
                begin
                    // reduce p1 mod m1 then multiply
                    red_req.start   = 1'b1;
                    red_req.operand = RED_W'(p1_reg);
                    red_req.modulus = mod1_reg;
                    prod_next = ENTRY_W'(1);
                end
                else if (red_rsp.done)
                begin
                    p1_next = red_rsp.remainder;
                    red_req.start   = 1'b1;
                    red_req.operand = RED_W'(h1_reg);
                    red_req.modulus = mod1_reg;
                    state_next = S_APP_H1;
                end
            end
            S_APP_H1:
            begin
                if (red_rsp.done)
                begin
                    h1_next = red_rsp.remainder;
                    red_req.start   = 1'b1;
                    red_req.operand = RED_W'(p2_reg);
                    red_req.modulus = mod2_reg;
                    state_next = S_APP_P2;
                end
            end
            S_APP_P2:
            begin
                if (red_rsp.done)
                begin
                    p2_next = red_rsp.remainder;
                    red_req.start   = 1'b1;
                    red_req.operand = RED_W'(h2_reg);
                    red_req.modulus = mod2_reg;
                    state_next = S_APP_H2;
                end
            end
            S_APP_H2:
            begin
                if (red_rsp.done)
                begin
                    h2_next = red_rsp.remainder;
                    prod_next = ENTRY_W'(0);
                    a1_next = '0;
                    state_next = S_APP_WR;
                end
            end
            S_APP_WR:
            begin
                // four product reductions, sequenced by a1_reg as step index
                if (a1_reg == WORD_W'(0))
                begin
                    prod_next = p1_reg * base1_reg;
                    a1_next = WORD_W'(1);
                end
                else if (a1_reg == WORD_W'(1))
                begin
                    red_req.start   = 1'b1;
                    red_req.operand = RED_W'(prod_reg);
                    red_req.modulus = mod1_reg;
                    prod_next = h1_reg * base1_reg;
                    a1_next = WORD_W'(2);
                end
                else if (a1_reg == WORD_W'(2) && red_rsp.done)
                begin
                    p1_next = red_rsp.remainder;
                    red_req.start   = 1'b1;
                    red_req.operand = RED_W'(prod_reg) + RED_W'(item_reg.char_byte);
                    red_req.modulus = mod1_reg;
                    prod_next = p2_reg * base2_reg;
                    a1_next = WORD_W'(3);
                end
                else if (a1_reg == WORD_W'(3) && red_rsp.done)
                begin
                    h1_next = red_rsp.remainder;
                    red_req.start   = 1'b1;
                    red_req.operand = RED_W'(prod_reg);
                    red_req.modulus = mod2_reg;
                    prod_next = h2_reg * base2_reg;
                    a1_next = WORD_W'(4);
                end
                else if (a1_reg == WORD_W'(4) && red_rsp.done)
                begin
                    p2_next = red_rsp.remainder;
                    red_req.start   = 1'b1;
                    red_req.operand = RED_W'(prod_reg) + RED_W'(item_reg.char_byte);
                    red_req.modulus = mod2_reg;
                    a1_next = WORD_W'(5);
                end
                else if (a1_reg == WORD_W'(5) && red_rsp.done)
                begin
                    h_we = 1'b1;
                    p_we = 1'b1;
                    ram_addr = ADDR_W'(len_reg);
                    h_wdata = {red_rsp.remainder, h1_reg};
                    p_wdata = {p2_reg, p1_reg};
                    len_next = len_reg + LEN_W'(1);
                    state_next = S_OUT;
                end
            end
            S_RD_B:
            begin
                ram_addr = ADDR_W'(l_ext - LEN_W'(1));
                state_next = S_WAIT_B;
            end
            S_WAIT_B:
            begin
                if (l_ext == '0)
                begin
                    a1_next = '0; a2_next = '0;
                end
                else
                begin
                    a1_next = h_rdata[WORD_W-1:0];
                    a2_next = h_rdata[ENTRY_W-1:WORD_W];
                end
                red_req.start   = 1'b1;
                red_req.operand = RED_W'(h1_reg);
                red_req.modulus = mod1_reg;
                state_next = S_Q_RED_HR1;
            end
            S_Q_RED_HR1:
            begin
                if (red_rsp.done)
                begin
                    h1_next = red_rsp.remainder;
                    red_req.start   = 1'b1;
                    red_req.operand = RED_W'(h2_reg);
                    red_req.modulus = mod2_reg;
                    state_next = S_Q_RED_HR2;
                end
            end
            S_Q_RED_HR2:
            begin
                if (red_rsp.done)
                begin
                    h2_next = red_rsp.remainder;
                    red_req.start   = 1'b1;
                    red_req.operand = RED_W'(a1_reg);
                    red_req.modulus = mod1_reg;
                    state_next = S_Q_RED_HL1;
                end
            end
            S_Q_RED_HL1:
            begin
                if (red_rsp.done)
                begin
                    a1_next = red_rsp.remainder;
                    red_req.start   = 1'b1;
                    red_req.operand = RED_W'(a2_reg);
                    red_req.modulus = mod2_reg;
                    state_next = S_Q_RED_HL2;
                end
            end
            S_Q_RED_HL2:
            begin
                if (red_rsp.done)
                begin
                    a2_next = red_rsp.remainder;
                    red_req.start   = 1'b1;
                    red_req.operand = RED_W'(p1_reg);
                    red_req.modulus = mod1_reg;
                    state_next = S_Q_RED_PW1;
                end
            end
            S_Q_RED_PW1:
            begin
                if (red_rsp.done)
                begin
                    p1_next = red_rsp.remainder;
                    red_req.start   = 1'b1;
                    red_req.operand = RED_W'(p2_reg);
                    red_req.modulus = mod2_reg;
                    state_next = S_Q_RED_PW2;
                end
            end
            S_Q_RED_PW2:
            begin
                if (red_rsp.done)
                begin
                    p2_next = red_rsp.remainder;
                    prod_next = a1_reg * p1_reg;
                    state_next = S_Q_MUL1;
                end
            end
            S_Q_MUL1:
            begin
                red_req.start   = 1'b1;
                red_req.operand = RED_W'(prod_reg);
                red_req.modulus = mod1_reg;
                prod_next = a2_reg * p2_reg;
                state_next = S_Q_MUL2;
            end
            S_Q_MUL2:
            begin
                if (red_rsp.done)
                begin
                    // num1 = (hr + m - sub) mod m, sub and hr below m
                    a1_next = (h1_reg >= red_rsp.remainder)
                        ? h1_reg - red_rsp.remainder
                        : WORD_W'({1'b0, h1_reg} + {1'b0, m1_eff}
                                  - {1'b0, red_rsp.remainder});
                    red_req.start   = 1'b1;
                    red_req.operand = RED_W'(prod_reg);
                    red_req.modulus = mod2_reg;
                    state_next = S_Q_NUM2;
                end
            end
            S_Q_NUM2:
            begin
                if (red_rsp.done)
                begin
                    a2_next = (h2_reg >= red_rsp.remainder)
                        ? h2_reg - red_rsp.remainder
                        : WORD_W'({1'b0, h2_reg}
                                  + {1'b0, ((mod2_reg == '0) ? WORD_W'(1) : mod2_reg)}
                                  - {1'b0, red_rsp.remainder});
                    state_next = S_Q_NUM1;
                end
            end
            S_Q_NUM1:
            begin
                prod_next = a2_reg * m1_eff;
                state_next = S_Q_COMB;
            end
            S_Q_COMB:
            begin
                res_next.hash_value = HASH_W'(prod_reg + ENTRY_W'(a1_reg));
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // wait here while the output register still holds an item
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        res_reg  <= res_next;
        out_data_reg <= out_data_next;
        h1_reg <= h1_next; h2_reg <= h2_next;
        p1_reg <= p1_next; p2_reg <= p2_next;
        a1_reg <= a1_next; a2_reg <= a2_next;
        prod_reg <= prod_next;
    end

    // length never exceeds the store
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(MAX_LEN))
        else $error("length above store depth");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ch.ready) |=> (out_valid_reg && $stable(out_data_reg)))
        else $error("stalled result changed");

    // length only grows by one per append
    a_len_step: assert property (@(posedge clk) disable iff (!rst_n)
        (len_reg != $past(len_reg)) |-> (len_reg == '0
            || len_reg == $past(len_reg) + LEN_W'(1)))
        else $error("length jumped");

    // a flagged result (bad range or full) reports zero hash
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.status != ST_OK) |-> out_data_reg.hash_value == '0)
        else $error("flagged result with nonzero hash");
endmodule

### tb/dmsh_tb_if.sv
// ----------------------------------------------------------------------------
// dmsh_tb_if
// testbench types: the unused item kind and one row of the directed stimulus table
// ----------------------------------------------------------------------------
package dmsh_tb_pkg;

    import dmsh_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [7:0]        char_byte;
        logic [12:0]       range_start;
        logic [12:0]       range_end;
        logic              known;
        logic [HASH_W-1:0] hash_value;
        logic [STATUS_W-1:0] status;
    } stim_row_t;

endpackage

### tb/double_modular_substring_hash_tb.sv
// ----------------------------------------------------------------------------
// double_modular_substring_hash_tb
// drives clear, append, substring query and unused-kind items into the block;
// checks results against a double-modulus prefix hash predictor or table row
// ----------------------------------------------------------------------------
module double_modular_substring_hash_tb;

    import dmsh_pkg::*;
    import dmsh_tb_pkg::*;

    logic clk;
    logic rst_n;

    dmsh_if #(.payload_t(in_item_t))  in_ch ();
    dmsh_if #(.payload_t(out_item_t)) out_ch ();
    dmsh_if #(.payload_t(cfg_item_t)) cfg_ch ();

    double_modular_substring_hash uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source),
        .cfg_ch (cfg_ch.sink)
    );

    localparam longint CYCLE_LIMIT = 8000000;

    // predictor state
    logic [WORD_W-1:0] mod_one, mod_two, base_a, base_b;
    int unsigned       str_len;
    logic [WORD_W-1:0] hash_tab_one [MAX_LEN];
    logic [WORD_W-1:0] hash_tab_two [MAX_LEN];
    logic [WORD_W-1:0] pow_tab_one  [MAX_LEN];
    logic [WORD_W-1:0] pow_tab_two  [MAX_LEN];

    out_item_t pending_results [$];
    int        fail_count = 0;
    longint    cycle_count = 0;
    int        send_idle_pct;
    int        recv_idle_pct;
    logic      recv_hold;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("double_modular_substring_hash: mismatch");
            $finish;
        end
    end

    function automatic longint unsigned prefix_at(int unsigned k, logic is_pow, logic second,
                                                  longint unsigned m);
        if (k == 0)
            return is_pow ? (1 % m) : 0;
        if (is_pow)
            return (second ? pow_tab_two[k-1] : pow_tab_one[k-1]) % m;
        return (second ? hash_tab_two[k-1] : hash_tab_one[k-1]) % m;
    endfunction

    function automatic longint unsigned substring_hash(int unsigned l, int unsigned r,
                                                       logic second, longint unsigned m);
        longint unsigned hr, hl, pw, sub;
        hr  = prefix_at(r, 1'b0, second, m);
        hl  = prefix_at(l, 1'b0, second, m);
        pw  = prefix_at(r - l, 1'b1, second, m);
        sub = (hl * pw) % m;
        return (hr + m - sub) % m;
    endfunction

    function automatic out_item_t hash_predict(in_item_t it);
        out_item_t       res;
        longint unsigned m1, m2, h, p, n1, n2;
        int unsigned     n;
        m1  = (mod_one == 0) ? 1 : mod_one;
        m2  = (mod_two == 0) ? 1 : mod_two;
        res = '0;
        res.status = ST_OK;
        case (it.kind)
            KIND_CLEAR: str_len = 0;
            KIND_APPEND:
            begin
                if (str_len >= MAX_LEN)
                    res.status = ST_FULL;
                else
                begin
                    n = str_len;
                    h = prefix_at(n, 1'b0, 1'b0, m1);
                    p = prefix_at(n, 1'b1, 1'b0, m1);
                    hash_tab_one[n] = WORD_W'((h * base_a + it.char_byte) % m1);
                    pow_tab_one[n]  = WORD_W'((p * base_a) % m1);
                    h = prefix_at(n, 1'b0, 1'b1, m2);
                    p = prefix_at(n, 1'b1, 1'b1, m2);
                    hash_tab_two[n] = WORD_W'((h * base_b + it.char_byte) % m2);
                    pow_tab_two[n]  = WORD_W'((p * base_b) % m2);
                    str_len = n + 1;
                end
            end
            KIND_QUERY:
            begin
                if (it.range_start > it.range_end || it.range_end > str_len)
                    res.status = ST_BAD_RANGE;
                else
                begin
                    n1 = substring_hash(it.range_start, it.range_end, 1'b0, m1);
                    n2 = substring_hash(it.range_start, it.range_end, 1'b1, m2);
                    res.hash_value = HASH_W'(n1 + n2 * m1);
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // result checking
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result hash %h status %0d", $time,
                         out_ch.payload.hash_value, out_ch.payload.status);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (want.hash_value !== out_ch.payload.hash_value)
                begin
                    $display("%0t: hash_value expected %h actual %h", $time,
                             want.hash_value, out_ch.payload.hash_value);
                    fail_count++;
                end
                if (want.status !== out_ch.payload.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, out_ch.payload.status);
                    fail_count++;
                end
            end
        end
    end

    // receiver ready
    always @(negedge clk)
    begin
        if (recv_hold)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] val);
        @(negedge clk);
        cfg_ch.payload <= '{index: idx, data: val};
        cfg_ch.valid   <= 1'b1;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        case (idx)
            REG_MOD_ONE:  mod_one = val;
            REG_MOD_TWO:  mod_two = val;
            REG_BASE_ONE: base_a  = val;
            default:      base_b  = val;
        endcase
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (500) @(negedge clk);
    endtask

    task automatic send_item(in_item_t it, logic known, out_item_t typed);
        out_item_t res;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.payload <= it;
        in_ch.valid   <= 1'b1;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        res = hash_predict(it);
        if (known)
            res = typed;
        pending_results.insert(pending_results.size(), res);
    endtask

    task automatic random_item(int short_max);
        in_item_t it;
        int       pick;
        pick = $urandom_range(99);
        it.char_byte = 8'($urandom);
        if (pick < 2)
            it.kind = KIND_CLEAR;
        else if (pick < 4)
            it.kind = KIND_UNUSED;
        else if (pick < 45 && str_len < short_max)
            it.kind = KIND_APPEND;
        else
            it.kind = KIND_QUERY;
        if (it.kind == KIND_APPEND && str_len >= MAX_LEN)
            it.kind = KIND_QUERY;
        if ($urandom_range(9) == 0)
        begin
            it.range_start = 13'($urandom);
            it.range_end   = 13'($urandom);
        end
        else
        begin
            it.range_end   = 13'($urandom_range(str_len));
            it.range_start = 13'($urandom_range(it.range_end));
        end
        send_item(it, 1'b0, '0);
    endtask

    task automatic random_config();
        int sel;
        sel = $urandom_range(3);
        case (sel)
            0:
            begin
                cfg_write(REG_MOD_ONE, 30'd1000000007);
                cfg_write(REG_MOD_TWO, 30'd1000000009);
            end
            1:
            begin
                cfg_write(REG_MOD_ONE, 30'h3FFFFFFF);
                cfg_write(REG_MOD_TWO, 30'd2);
            end
            2:
            begin
                cfg_write(REG_MOD_ONE, WORD_W'($urandom));
                cfg_write(REG_MOD_TWO, WORD_W'($urandom));
            end
            default:
            begin
                cfg_write(REG_MOD_ONE, 30'd0);
                cfg_write(REG_MOD_TWO, 30'd65521);
            end
        endcase
        cfg_write(REG_BASE_ONE, WORD_W'($urandom_range(1, 30'h3FFFFFFF)));
        cfg_write(REG_BASE_TWO, (sel == 1) ? 30'h3FFFFFFF
                                           : WORD_W'($urandom_range(1, 1000)));
    endtask

    stim_row_t directed_rows [] = '{
        '{KIND_QUERY,  8'h00, 13'd0,    13'd0,    1'b1, 60'd0, ST_OK},
        '{KIND_QUERY,  8'h00, 13'd0,    13'd1,    1'b1, 60'd0, ST_BAD_RANGE},
        '{KIND_APPEND, 8'h00, 13'd0,    13'd0,    1'b1, 60'd0, ST_OK},
        '{KIND_APPEND, 8'hFF, 13'd8191, 13'd8191, 1'b1, 60'd0, ST_OK},
        '{KIND_APPEND, 8'h5A, 13'd0,    13'd0,    1'b1, 60'd0, ST_OK},
        '{KIND_APPEND, 8'hA5, 13'd0,    13'd0,    1'b1, 60'd0, ST_OK},
        '{KIND_QUERY,  8'h00, 13'd0,    13'd4,    1'b0, 60'd0, ST_OK},
        '{KIND_QUERY,  8'hFF, 13'd1,    13'd3,    1'b0, 60'd0, ST_OK},
        '{KIND_QUERY,  8'h00, 13'd3,    13'd4,    1'b0, 60'd0, ST_OK},
        '{KIND_QUERY,  8'h00, 13'd2,    13'd2,    1'b1, 60'd0, ST_OK},
        '{KIND_QUERY,  8'h00, 13'd3,    13'd2,    1'b1, 60'd0, ST_BAD_RANGE},
        '{KIND_QUERY,  8'h00, 13'd0,    13'd5,    1'b1, 60'd0, ST_BAD_RANGE},
        '{KIND_QUERY,  8'h00, 13'd8191, 13'd8191, 1'b1, 60'd0, ST_BAD_RANGE},
        '{KIND_QUERY,  8'h00, 13'd4096, 13'd4096, 1'b1, 60'd0, ST_BAD_RANGE},
        '{KIND_UNUSED, 8'hFF, 13'd8191, 13'd0,    1'b1, 60'd0, ST_OK},
        '{KIND_CLEAR,  8'hFF, 13'd8191, 13'd8191, 1'b1, 60'd0, ST_OK},
        '{KIND_QUERY,  8'h00, 13'd0,    13'd1,    1'b1, 60'd0, ST_BAD_RANGE},
        '{KIND_APPEND, 8'h01, 13'd0,    13'd0,    1'b1, 60'd0, ST_OK},
        '{KIND_QUERY,  8'h00, 13'd0,    13'd1,    1'b0, 60'd0, ST_OK}
    };

    initial
    begin
        in_item_t  it;
        out_item_t typed;
        rst_n          = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.payload  = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.payload = '0;
        recv_hold      = 1'b0;
        send_idle_pct  = 18;
        recv_idle_pct  = 81;
        mod_one        = MOD_RESET;
        mod_two        = MOD_RESET;
        base_a         = BASE1_RESET;
        base_b         = BASE2_RESET;
        str_len        = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
        begin
            it    = '{directed_rows[i].kind, directed_rows[i].char_byte,
                      directed_rows[i].range_start, directed_rows[i].range_end};
            typed = '{directed_rows[i].hash_value, directed_rows[i].status};
            send_item(it, directed_rows[i].known, typed);
        end

        // receiver stalls for a long time while items keep coming
        fork
            begin
                recv_hold = 1'b1;
                repeat (3000) @(negedge clk);
                recv_hold = 1'b0;
            end
            repeat (6) random_item(64);
        join

        // sender pauses until everything is back, then config changes
        drain_results();
        random_config();

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 18 : (phase == 1) ? 81 : 0;
            recv_idle_pct = (phase == 0) ? 81 : (phase == 1) ? 18 : 0;
            for (int n = 0; n < 360; n++)
                random_item(48);
            drain_results();
            random_config();
        end

        drain_results();
        if (fail_count == 0)
            $display("double_modular_substring_hash: match");
        else
            $display("double_modular_substring_hash: mismatch");
        $finish;
    end

endmodule
